// File: rtl/rv32_integer_execute_unit_defines.svh
// Assertion macros shared by the execute unit RTL.
// Depends on nothing; files that check properties include it by name.
`ifndef RV32_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define RV32_INTEGER_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RV32IEU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("execute unit check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RV32IEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("execute unit check failed");

`endif

// File: rtl/rv32ieu_pkg.sv
// Shared types, constants and functions of the RV32 integer execute unit.
// Depends on nothing; every RTL module imports it.
`timescale 1ns / 1ps

package rv32ieu_pkg;

	localparam int MEM_DEPTH_DEF = 1024;
	localparam int XLEN          = 32;
	localparam int REG_AW        = 5;
	localparam int NREGS         = 32;
	localparam int OP_W          = 6;
	localparam int S_TDATA_W     = 120;
	localparam int M_TDATA_W     = 72;

	typedef enum logic [OP_W-1:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SLT, OP_SLTU,
		OP_SLL, OP_SRL, OP_SRA,
		OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI,
		OP_SRLI, OP_SRAI,
		OP_LUI, OP_AUIPC,
		OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
		OP_SB, OP_SH, OP_SW,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
		OP_JAL, OP_JALR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [REG_AW-1:0] rd;
		logic             wr;
		logic             jl;
		logic             ld;
		logic             st;
		logic [XLEN-1:0]  val;
		logic [XLEN-1:0]  npc;
		logic [XLEN-1:0]  sum;
		logic [XLEN-1:0]  sdata;
	} ex_t;

	typedef struct packed {
		logic              we;
		logic [REG_AW-1:0] addr;
		logic [XLEN-1:0]   data;
	} rf_wr_t;

	function automatic logic [XLEN-1:0] alu_f(input op_t k, input logic [XLEN-1:0] a,
			input logic [XLEN-1:0] b);
		logic [XLEN-1:0] r;
		case (k)
			OP_ADD:  r = a + b;
			OP_SUB:  r = a - b;
			OP_MUL:  r = a * b;
			OP_AND:  r = a & b;
			OP_OR:   r = a | b;
			OP_XOR:  r = a ^ b;
			OP_SLT:  r = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
			OP_SLTU: r = {{(XLEN-1){1'b0}}, a < b};
			OP_SLL:  r = a << b[4:0];
			OP_SRL:  r = a >> b[4:0];
			OP_SRA:  r = XLEN'($signed(a) >>> b[4:0]);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [XLEN-1:0] load_fmt(input op_t k, input logic [XLEN-1:0] w);
		logic [XLEN-1:0] r;
		case (k)
			OP_LB:   r = {{24{w[7]}}, w[7:0]};
			OP_LH:   r = {{16{w[15]}}, w[15:0]};
			OP_LBU:  r = {24'd0, w[7:0]};
			OP_LHU:  r = {16'd0, w[15:0]};
			default: r = w;
		endcase
		return r;
	endfunction

	function automatic logic [XLEN-1:0] store_merge(input op_t k, input logic [XLEN-1:0] w,
			input logic [XLEN-1:0] d);
		logic [XLEN-1:0] r;
		case (k)
			OP_SB:   r = {w[31:8], d[7:0]};
			OP_SH:   r = {w[31:16], d[15:0]};
			default: r = d;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/rv32ieu_regfile.sv
// Register file: 32 words, one write port, two registered read ports.
// Depends on rv32ieu_pkg.
`timescale 1ns / 1ps

module rv32ieu_regfile (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           re,
	input  logic [rv32ieu_pkg::REG_AW-1:0] raddr_a,
	input  logic [rv32ieu_pkg::REG_AW-1:0] raddr_b,
	input  rv32ieu_pkg::rf_wr_t            wr,
	output logic [rv32ieu_pkg::XLEN-1:0]   rdata_a,
	output logic [rv32ieu_pkg::XLEN-1:0]   rdata_b
);
	import rv32ieu_pkg::*;

	logic [XLEN-1:0]   rf_mem [NREGS];
	logic [NREGS-1:0]  valid_q;
	logic [REG_AW-1:0] raddr_a_q;
	logic [REG_AW-1:0] raddr_b_q;
	logic [XLEN-1:0]   rdata_a_q;
	logic [XLEN-1:0]   rdata_b_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			rf_mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Read data follows later writes to the same register while it is held.
	always_ff @(posedge clk) begin
		if (re) begin
			raddr_a_q <= raddr_a;
			raddr_b_q <= raddr_b;
			if (wr.we && wr.addr == raddr_a) begin
				rdata_a_q <= wr.data;
			end else begin
				rdata_a_q <= valid_q[raddr_a] ? rf_mem[raddr_a] : '0;
			end
			if (wr.we && wr.addr == raddr_b) begin
				rdata_b_q <= wr.data;
			end else begin
				rdata_b_q <= valid_q[raddr_b] ? rf_mem[raddr_b] : '0;
			end
		end else begin
			if (wr.we && wr.addr == raddr_a_q) begin
				rdata_a_q <= wr.data;
			end
			if (wr.we && wr.addr == raddr_b_q) begin
				rdata_b_q <= wr.data;
			end
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// File: rtl/rv32ieu_dmem.sv
// Data memory: one word per address, registered read, clearing pass after reset.
// Depends on rv32ieu_pkg.
`timescale 1ns / 1ps

module rv32ieu_dmem #(
	parameter int DEPTH = rv32ieu_pkg::MEM_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [rv32ieu_pkg::XLEN-1:0] wdata,
	output logic [rv32ieu_pkg::XLEN-1:0] rdata,
	output logic                         busy
);
	import rv32ieu_pkg::*;

	logic [XLEN-1:0] mem [DEPTH];
	logic [XLEN-1:0] rdata_q;
	logic [AW-1:0]   clr_idx_q;
	logic            clr_busy_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [XLEN-1:0] mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign mem_we    = clr_busy_q || we;
	assign mem_waddr = clr_busy_q ? clr_idx_q : waddr;
	assign mem_wdata = clr_busy_q ? '0 : wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// A write in the same cycle as a read of that word is passed through.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && waddr == raddr) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

// File: rtl/rv32ieu_alu.sv
// Execute logic: ALU, immediates, branch decision, jump targets, address sum.
// Depends on rv32ieu_pkg.
`timescale 1ns / 1ps

module rv32ieu_alu (
	input  logic [rv32ieu_pkg::OP_W-1:0]   op,
	input  logic [rv32ieu_pkg::REG_AW-1:0] rd,
	input  logic [rv32ieu_pkg::XLEN-1:0]   a,
	input  logic [rv32ieu_pkg::XLEN-1:0]   b,
	input  logic [rv32ieu_pkg::XLEN-1:0]   imm,
	input  logic [rv32ieu_pkg::XLEN-1:0]   pc,
	input  logic [rv32ieu_pkg::XLEN-1:0]   tgt,
	output rv32ieu_pkg::ex_t               ex
);
	import rv32ieu_pkg::*;

	op_t             opc;
	op_t             imm_kind;
	logic            taken;
	logic [XLEN-1:0] pc_plus4;
	logic [XLEN-1:0] imm_hi;

	assign opc      = op_t'(op);
	assign pc_plus4 = pc + XLEN'(4);
	assign imm_hi   = imm << 12;

	always_comb begin
		case (opc)
			OP_SLTI:  imm_kind = OP_SLT;
			OP_SLTIU: imm_kind = OP_SLTU;
			OP_XORI:  imm_kind = OP_XOR;
			OP_ORI:   imm_kind = OP_OR;
			OP_ANDI:  imm_kind = OP_AND;
			OP_SLLI:  imm_kind = OP_SLL;
			OP_SRLI:  imm_kind = OP_SRL;
			OP_SRAI:  imm_kind = OP_SRA;
			default:  imm_kind = OP_ADD;
		endcase
	end

	always_comb begin
		case (opc)
			OP_BEQ:  taken = (a == b);
			OP_BNE:  taken = (a != b);
			OP_BLT:  taken = ($signed(a) < $signed(b));
			OP_BGE:  taken = !($signed(a) < $signed(b));
			OP_BLTU: taken = (a < b);
			OP_BGEU: taken = (a >= b);
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		ex       = '0;
		ex.op    = opc;
		ex.rd    = rd;
		ex.npc   = pc_plus4;
		ex.sum   = a + imm;
		ex.sdata = b;
		if (opc inside {[OP_ADD:OP_SRA]}) begin
			ex.val = alu_f(opc, a, b);
			ex.wr  = 1'b1;
		end else if (opc inside {[OP_ADDI:OP_SRAI]}) begin
			ex.val = alu_f(imm_kind, a, imm);
			ex.wr  = 1'b1;
		end else if (opc == OP_LUI) begin
			ex.val = imm_hi;
			ex.wr  = 1'b1;
		end else if (opc == OP_AUIPC) begin
			ex.val = pc + imm_hi;
			ex.wr  = 1'b1;
		end else if (opc inside {[OP_LB:OP_LHU]}) begin
			ex.wr = 1'b1;
			ex.ld = 1'b1;
		end else if (opc inside {[OP_SB:OP_SW]}) begin
			ex.st = 1'b1;
		end else if (opc inside {[OP_BEQ:OP_BGEU]}) begin
			if (taken) begin
				ex.npc = tgt;
			end
		end else if (opc == OP_JAL) begin
			ex.val = pc_plus4;
			ex.npc = tgt;
			ex.wr  = 1'b1;
			ex.jl  = 1'b1;
		end else if (opc == OP_JALR) begin
			ex.val = pc_plus4;
			ex.npc = {ex.sum[XLEN-1:1], 1'b0};
			ex.wr  = 1'b1;
			ex.jl  = 1'b1;
		end
	end

endmodule

// File: rtl/rv32_integer_execute_unit.sv
// Top level of the RV32 integer execute unit: five-stage pipeline around the
// register file and data memory. Depends on rv32ieu_pkg, the defines header,
// rv32ieu_regfile, rv32ieu_dmem and rv32ieu_alu.
//
// Usage: one decoded instruction word enters on the s_ channel; exactly one
// result word leaves on the m_ channel for each, in order.
// Path: an accepted instruction passes through execute, two address-reduction
// stages, correction and memory read, memory word and the output register,
// where m_tvalid rises.
// Throughput: one instruction per cycle while m_tready is high and no load
// wait or memory clear holds the pipeline. ALU, lui, auipc and link results
// are forwarded to the following instructions without delay. An instruction
// using a load's value waits for its write-back; the memory read is in stage four.
// Memory addresses are reduced modulo MEM_DEPTH by a multiply by the reciprocal
// and one correcting subtract, over stages two to four.
// Reset: all registers and memory words read as zero. After reset the data
// memory is swept clear word by word, and s_tready stays low until the sweep ends.
// Stalls: when m_tready is low the finished result is held in the output
// register and the pipeline keeps accepting words until its five stages fill.
`timescale 1ns / 1ps
`include "rv32_integer_execute_unit_defines.svh"

module rv32_integer_execute_unit #(
	parameter int MEM_DEPTH = rv32ieu_pkg::MEM_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// op, dest_reg, src1_reg, src2_reg, immediate, cur_pc, branch_target
	input  logic [rv32ieu_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// next_pc, written_value, reg_written, error_code
	output logic [rv32ieu_pkg::M_TDATA_W-1:0] m_tdata
);
	import rv32ieu_pkg::*;

	localparam int              AW      = $clog2(MEM_DEPTH);
	localparam logic [XLEN-1:0] DEPTH_W = XLEN'(MEM_DEPTH);
	localparam logic [XLEN-1:0] RECIP   = XLEN'((64'd1 << 32) / MEM_DEPTH);

	logic              acc;
	logic              clr_busy;
	logic              adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic              free_s1, free_s2, free_s3, free_s4, free_s5;
	logic              stall_a, stall_b;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [OP_W-1:0]   op_s1;
	logic [REG_AW-1:0] rd_s1, src1_s1, src2_s1;
	logic [XLEN-1:0]   imm_s1, pc_s1, tgt_s1;
	ex_t               ex_s2, ex_s3, ex_s4, ex_s5;
	logic [XLEN-1:0]   q_s3;
	logic [XLEN-1:0]   qd_s4;
	logic [AW-1:0]     addr_s5;

	logic [XLEN-1:0]   rf_a, rf_b, a_fw, b_fw;
	ex_t               ex;
	ex_t               stg_ex [4];
	logic [3:0]        stg_v;
	rf_wr_t            rf_wr;

	logic [63:0]       prod;
	logic [XLEN-1:0]   rem, rem_adj;
	logic [AW-1:0]     mem_addr;
	logic [XLEN-1:0]   dm_rdata;
	logic              dm_we;
	logic [XLEN-1:0]   dm_wdata;

	logic              wr_ok;
	logic [XLEN-1:0]   val_final;

	logic              out_vld_q;
	logic [XLEN-1:0]   out_npc_q, out_val_q;
	logic              out_wr_q, out_err_q;

	// Handshake chain from the output register back to the input.
	assign adv_s5  = v_s5 && (!out_vld_q || m_tready);
	assign free_s5 = !v_s5 || adv_s5;
	assign adv_s4  = v_s4 && free_s5;
	assign free_s4 = !v_s4 || adv_s4;
	assign adv_s3  = v_s3 && free_s4;
	assign free_s3 = !v_s3 || adv_s3;
	assign adv_s2  = v_s2 && free_s3;
	assign free_s2 = !v_s2 || adv_s2;
	assign adv_s1  = v_s1 && !stall_a && !stall_b && free_s2;
	assign free_s1 = !v_s1 || adv_s1;
	assign s_tready = !clr_busy && free_s1;
	assign acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			v_s1      <= acc || (v_s1 && !adv_s1);
			v_s2      <= adv_s1 || (v_s2 && !adv_s2);
			v_s3      <= adv_s2 || (v_s3 && !adv_s3);
			v_s4      <= adv_s3 || (v_s4 && !adv_s4);
			v_s5      <= adv_s4 || (v_s5 && !adv_s5);
			out_vld_q <= adv_s5 || (out_vld_q && !m_tready);
		end
	end

	// Stage 1: decoded fields, operands arrive from the register file.
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= s_tdata[5:0];
			rd_s1   <= s_tdata[10:6];
			src1_s1 <= s_tdata[15:11];
			src2_s1 <= s_tdata[20:16];
			imm_s1  <= s_tdata[52:21];
			pc_s1   <= s_tdata[84:53];
			tgt_s1  <= s_tdata[116:85];
		end
	end

	rv32ieu_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (acc),
		.raddr_a (s_tdata[15:11]),
		.raddr_b (s_tdata[20:16]),
		.wr      (rf_wr),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	always_comb begin
		stg_v     = {v_s2, v_s3, v_s4, v_s5};
		stg_ex[0] = ex_s5;
		stg_ex[1] = ex_s4;
		stg_ex[2] = ex_s3;
		stg_ex[3] = ex_s2;
	end

	// Oldest stage first, so the youngest older writer wins. A pending load
	// holds the instruction until it has written back.
	always_comb begin
		a_fw    = rf_a;
		b_fw    = rf_b;
		stall_a = 1'b0;
		stall_b = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (stg_v[i] && stg_ex[i].wr && stg_ex[i].rd != '0 &&
					stg_ex[i].rd == src1_s1) begin
				stall_a = stg_ex[i].ld;
				a_fw    = stg_ex[i].val;
			end
			if (stg_v[i] && stg_ex[i].wr && stg_ex[i].rd != '0 &&
					stg_ex[i].rd == src2_s1) begin
				stall_b = stg_ex[i].ld;
				b_fw    = stg_ex[i].val;
			end
		end
	end

	rv32ieu_alu u_alu (
		.op  (op_s1),
		.rd  (rd_s1),
		.a   (a_fw),
		.b   (b_fw),
		.imm (imm_s1),
		.pc  (pc_s1),
		.tgt (tgt_s1),
		.ex  (ex)
	);

	// Stages 2 to 4: address modulo MEM_DEPTH by reciprocal multiply.
	assign prod = 64'(ex_s2.sum) * 64'(RECIP);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ex_s2 <= ex;
		end
		if (adv_s2) begin
			ex_s3 <= ex_s2;
			q_s3  <= prod[63:32];
		end
		if (adv_s3) begin
			ex_s4 <= ex_s3;
			qd_s4 <= q_s3 * DEPTH_W;
		end
		if (adv_s4) begin
			ex_s5   <= ex_s4;
			addr_s5 <= mem_addr;
		end
	end

	assign rem      = ex_s4.sum - qd_s4;
	assign rem_adj  = (rem >= DEPTH_W) ? rem - DEPTH_W : rem;
	assign mem_addr = rem_adj[AW-1:0];

	// Stage 5: memory word arrives; loads format it, stores merge into it.
	assign dm_we    = adv_s5 && ex_s5.st;
	assign dm_wdata = store_merge(ex_s5.op, dm_rdata, ex_s5.sdata);

	rv32ieu_dmem #(
		.DEPTH (MEM_DEPTH),
		.AW    (AW)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (adv_s4),
		.raddr  (mem_addr),
		.we     (dm_we),
		.waddr  (addr_s5),
		.wdata  (dm_wdata),
		.rdata  (dm_rdata),
		.busy   (clr_busy)
	);

	assign wr_ok     = ex_s5.wr && ex_s5.rd != '0;
	assign val_final = ex_s5.ld ? load_fmt(ex_s5.op, dm_rdata) : ex_s5.val;

	always_comb begin
		rf_wr.we   = adv_s5 && wr_ok;
		rf_wr.addr = ex_s5.rd;
		rf_wr.data = val_final;
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			out_npc_q <= ex_s5.npc;
			out_val_q <= wr_ok ? val_final : '0;
			out_wr_q  <= wr_ok;
			out_err_q <= ex_s5.wr && ex_s5.rd == '0 && !ex_s5.jl;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_err_q, out_wr_q, out_val_q, out_npc_q};

	`RV32IEU_ASSERT_IMPLY(a_flags_exclusive, clk, arst_n, m_tvalid, !(m_tdata[64] && m_tdata[65]))
	`RV32IEU_ASSERT_IMPLY(a_err_no_value, clk, arst_n, m_tvalid && !m_tdata[64], m_tdata[63:32] == '0)
	`RV32IEU_ASSERT_NEXT(a_s5_holds, clk, arst_n, v_s5 && m_tvalid && !m_tready, v_s5)
	`RV32IEU_ASSERT_IMPLY(a_idle_while_clearing, clk, arst_n, clr_busy, !v_s1 && !v_s5 && !m_tvalid)

endmodule
